[hdl/bhpp_pkg.sv]
package bhpp_pkg;

    localparam int TIME_BITS_DEF   = 16;
    localparam int BUTTON_BITS_DEF = 32;

    localparam int FIELD_BITS  = 32;
    localparam int MS_BITS     = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_MASK   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MASK  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_HOLD  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMBO_HOLD   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_HOLD   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_PULSE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_PULSE  = 4'd7;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_PULSE = 1'b1;

    typedef struct packed {
        logic                  enable;
        logic [FIELD_BITS-1:0] combo_mask;
        logic [FIELD_BITS-1:0] switch_mask;
        logic [MS_BITS-1:0]    switch_hold_ms;
        logic [MS_BITS-1:0]    combo_hold_ms;
        logic [MS_BITS-1:0]    force_hold_ms;
        logic [MS_BITS-1:0]    toggle_pulse_ms;
        logic [MS_BITS-1:0]    force_pulse_ms;
    } cfg_t;

    typedef struct packed {
        logic pulsing;
        logic armed;
        logic power_out;
    } res_t;

endpackage

[hdl/bhpp_cfg_regs.sv]
module bhpp_cfg_regs
    import bhpp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                REG_ENABLE:       cfg_next.enable          = wr_data[0];
                REG_COMBO_MASK:   cfg_next.combo_mask      = wr_data[FIELD_BITS-1:0];
                REG_SWITCH_MASK:  cfg_next.switch_mask     = wr_data[FIELD_BITS-1:0];
                REG_SWITCH_HOLD:  cfg_next.switch_hold_ms  = wr_data[MS_BITS-1:0];
                REG_COMBO_HOLD:   cfg_next.combo_hold_ms   = wr_data[MS_BITS-1:0];
                REG_FORCE_HOLD:   cfg_next.force_hold_ms   = wr_data[MS_BITS-1:0];
                REG_TOGGLE_PULSE: cfg_next.toggle_pulse_ms = wr_data[MS_BITS-1:0];
                REG_FORCE_PULSE:  cfg_next.force_pulse_ms  = wr_data[MS_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/bhpp_engine.sv]
module bhpp_engine
    import bhpp_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int BUTTON_BITS = BUTTON_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  commit,
    input  logic                  req_type,
    input  logic [FIELD_BITS-1:0] buttons,
    input  logic [MS_BITS-1:0]    press_length_ms,
    input  cfg_t                  cfg,
    output res_t                  res
);

    localparam int CMP_W = (TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

    logic                 hold_armed_reg, hold_armed_next;
    logic                 hold_by_switch_reg, hold_by_switch_next;
    logic [TIME_BITS-1:0] hold_elapsed_reg, hold_elapsed_next;
    logic                 pulse_active_reg, pulse_active_next;
    logic [TIME_BITS-1:0] pulse_elapsed_reg, pulse_elapsed_next;
    logic [MS_BITS-1:0]   pulse_length_reg, pulse_length_next;
    logic                 drive_level_reg, drive_level_next;

    logic [BUTTON_BITS-1:0] btn, cmask, smask;
    logic                   sw, held;
    logic [TIME_BITS-1:0]   hold_inc, pulse_inc;
    logic [MS_BITS-1:0]     toggle_limit;
    logic                   pulse_done, toggle_due, force_due;

    assign btn   = buttons[BUTTON_BITS-1:0];
    assign cmask = cfg.combo_mask[BUTTON_BITS-1:0];
    assign smask = cfg.switch_mask[BUTTON_BITS-1:0];
    assign sw    = |(btn & smask);
    assign held  = ((btn & cmask) == cmask) || sw;

    // saturating increments
    assign hold_inc  = (hold_elapsed_reg == TMAX) ? TMAX : hold_elapsed_reg + 1'b1;
    assign pulse_inc = (pulse_elapsed_reg == TMAX) ? TMAX : pulse_elapsed_reg + 1'b1;

    assign toggle_limit = hold_by_switch_reg ? cfg.switch_hold_ms : cfg.combo_hold_ms;

    // a saturated counter has reached any limit
    assign pulse_done = (CMP_W'(pulse_inc) >= CMP_W'(pulse_length_reg)) || (pulse_inc == TMAX);
    assign toggle_due = (CMP_W'(hold_inc) >= CMP_W'(toggle_limit)) || (hold_inc == TMAX);
    assign force_due  = (CMP_W'(hold_inc) >= CMP_W'(cfg.force_hold_ms)) || (hold_inc == TMAX);

    always_comb begin
        hold_armed_next     = hold_armed_reg;
        hold_by_switch_next = hold_by_switch_reg;
        hold_elapsed_next   = hold_elapsed_reg;
        pulse_active_next   = pulse_active_reg;
        pulse_elapsed_next  = pulse_elapsed_reg;
        pulse_length_next   = pulse_length_reg;
        drive_level_next    = drive_level_reg;

        if (cfg.enable) begin
            if (req_type == REQ_PULSE) begin
                if (!pulse_active_reg) begin
                    pulse_active_next  = 1'b1;
                    hold_armed_next    = 1'b0;
                    drive_level_next   = 1'b1;
                    pulse_elapsed_next = '0;
                    pulse_length_next  = press_length_ms;
                end
            end else if (pulse_active_reg) begin
                pulse_elapsed_next = pulse_inc;
                if (pulse_done) begin
                    drive_level_next  = 1'b0;
                    hold_armed_next   = 1'b0;
                    pulse_active_next = 1'b0;
                end
            end else if (!held) begin
                hold_armed_next = 1'b0;
                if (hold_armed_reg) begin
                    hold_elapsed_next = hold_inc;
                    if (toggle_due) begin
                        pulse_active_next  = 1'b1;
                        drive_level_next   = 1'b1;
                        pulse_elapsed_next = '0;
                        pulse_length_next  = cfg.toggle_pulse_ms;
                    end
                end
            end else if (!hold_armed_reg) begin
                hold_armed_next     = 1'b1;
                hold_by_switch_next = sw;
                hold_elapsed_next   = '0;
            end else begin
                hold_elapsed_next = hold_inc;
                if (force_due) begin
                    pulse_active_next  = 1'b1;
                    hold_armed_next    = 1'b0;
                    drive_level_next   = 1'b1;
                    pulse_elapsed_next = '0;
                    pulse_length_next  = cfg.force_pulse_ms;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_armed_reg     <= 1'b0;
            hold_by_switch_reg <= 1'b0;
            hold_elapsed_reg   <= '0;
            pulse_active_reg   <= 1'b0;
            pulse_elapsed_reg  <= '0;
            pulse_length_reg   <= '0;
            drive_level_reg    <= 1'b0;
        end else if (commit) begin
            hold_armed_reg     <= hold_armed_next;
            hold_by_switch_reg <= hold_by_switch_next;
            hold_elapsed_reg   <= hold_elapsed_next;
            pulse_active_reg   <= pulse_active_next;
            pulse_elapsed_reg  <= pulse_elapsed_next;
            pulse_length_reg   <= pulse_length_next;
            drive_level_reg    <= drive_level_next;
        end
    end

    assign res.power_out = cfg.enable & drive_level_next;
    assign res.armed     = cfg.enable & hold_armed_next;
    assign res.pulsing   = cfg.enable & pulse_active_next;

endmodule

[hdl/button_hold_power_pulser_core.sv]
// Power-button pulser. Each input transfer is a 1 ms tick carrying the button
// bits (tuser = 0) or a direct pulse request (tuser = 1); every input transfer
// yields exactly one output transfer with the line level, armed and pulsing
// flags as they stand after that item. An item passes through an input
// register and then a result register, with the engine logic between them,
// so the block takes one item per clock when the output is not stalled; the
// output is driven from the result register. Configuration
// is written through the cfg_* channel (always ready) and must only change
// while the block is idle. Hold and pulse counters are TIME_BITS wide and
// saturate.
module button_hold_power_pulser_core
    import bhpp_pkg::*;
#(
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int BUTTON_BITS = BUTTON_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // buttons[31:0], press_length_ms[47:32]
    input  logic                  s_tuser,   // req_type

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // power_out[0], armed[1], pulsing[2], zero pad

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t res;

    logic                  in_valid_reg, in_valid_next;
    logic                  in_type_reg;
    logic [FIELD_BITS-1:0] in_buttons_reg;
    logic [MS_BITS-1:0]    in_len_reg;
    logic                  m_valid_reg, m_valid_next;
    res_t                  m_res_reg;
    logic                  advance;

    assign cfg_ready = 1'b1;

    bhpp_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    bhpp_engine #(
        .TIME_BITS   (TIME_BITS),
        .BUTTON_BITS (BUTTON_BITS)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .commit          (advance),
        .req_type        (in_type_reg),
        .buttons         (in_buttons_reg),
        .press_length_ms (in_len_reg),
        .cfg             (cfg),
        .res             (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_type_reg    <= s_tuser;
            in_buttons_reg <= s_tdata[FIELD_BITS-1:0];
            in_len_reg     <= s_tdata[FIELD_BITS+MS_BITS-1:FIELD_BITS];
        end
        if (advance) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-3){1'b0}}, m_res_reg.pulsing, m_res_reg.armed,
                       m_res_reg.power_out};

endmodule

[hdl/bhpp_checker.sv]
module bhpp_checker
    import bhpp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled output transfer holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // line is driven exactly while a pulse runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[0] == m_tdata[2])
        else $error("power_out and pulsing disagree");

    // a running pulse never coexists with a timed hold
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && m_tdata[2]))
        else $error("armed while pulsing");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind button_hold_power_pulser_core bhpp_checker u_bhpp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
